/* rtl/core/casb_pkg.sv */
// Package for the clipped alpha sprite blitter.
// Holds register indexes, size limits and the pixel type shared by the core.
// No dependencies.
`default_nettype none

package casb_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_SCREEN_WIDTH  = 3'd0,
    CFG_SCREEN_HEIGHT = 3'd1,
    CFG_SPRITE_LEFT   = 3'd2,
    CFG_SPRITE_TOP    = 3'd3,
    CFG_SPRITE_COLS   = 3'd4,
    CFG_SPRITE_ROWS   = 3'd5
  } cfg_idx_t;

  // Size limits and reset values
  localparam logic [12:0] MAX_SCREEN   = 13'd4096;
  localparam logic [10:0] MAX_SPRITE   = 11'd1024;
  localparam logic [10:0] MIN_SPRITE   = 11'd1;
  localparam logic [12:0] RST_SCREEN_W = 13'd1024;
  localparam logic [12:0] RST_SCREEN_H = 13'd768;
  localparam logic [10:0] RST_SPRITE_N = 11'd64;

  // One pixel: bytes 0..2 and alpha in byte 3
  typedef logic [3:0][7:0] pix_t;

endpackage

`default_nettype wire

/* rtl/core/clipped_alpha_sprite_blit.sv */
// Clipped alpha sprite blitter, top level.
// Depends on casb_pkg and casb_blend.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall | src and dst bytes of one texel
//   out_    | output    | out_valid/out_stall | write flag, index, pixel, last
//   cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One texel per cycle while out_stall is low; stages: texel register, result register.
// The multiply of row by screen width and the blend multipliers sit between those two.
// Synchronous active-low reset clears the config registers to their defaults,
// the column and row counters and both valid flags.
// A stalled result holds; the texel stage refills behind it, then in_stall rises.
`default_nettype none

module clipped_alpha_sprite_blit (
  input  wire         clk,
  input  wire         rst_n,
  // texel input
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [7:0]  in_src_byte0,
  input  wire  [7:0]  in_src_byte1,
  input  wire  [7:0]  in_src_byte2,
  input  wire  [7:0]  in_src_alpha,
  input  wire  [7:0]  in_dst_byte0,
  input  wire  [7:0]  in_dst_byte1,
  input  wire  [7:0]  in_dst_byte2,
  input  wire  [7:0]  in_dst_alpha,
  // result output
  output logic        out_valid,
  input  wire         out_stall,
  output logic        out_write_enable,
  output logic [23:0] out_pixel_index,
  output logic [7:0]  out_byte0,
  output logic [7:0]  out_byte1,
  output logic [7:0]  out_byte2,
  output logic [7:0]  out_alpha,
  output logic        out_last_texel,
  // configuration writes
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [2:0]  cfg_index,
  input  wire  [12:0] cfg_data
);

  // Configuration registers
  logic [12:0] scr_w_r, scr_h_r, left_r, top_r;
  logic [10:0] cols_r, rows_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r <= casb_pkg::RST_SCREEN_W;
      scr_h_r <= casb_pkg::RST_SCREEN_H;
      left_r  <= 13'd0;
      top_r   <= 13'd0;
      cols_r  <= casb_pkg::RST_SPRITE_N;
      rows_r  <= casb_pkg::RST_SPRITE_N;
    end else if (cfg_valid && cfg_ready) begin
      case (casb_pkg::cfg_idx_t'(cfg_index))
        casb_pkg::CFG_SCREEN_WIDTH:  scr_w_r <= cfg_data;
        casb_pkg::CFG_SCREEN_HEIGHT: scr_h_r <= cfg_data;
        casb_pkg::CFG_SPRITE_LEFT:   left_r  <= cfg_data;
        casb_pkg::CFG_SPRITE_TOP:    top_r   <= cfg_data;
        casb_pkg::CFG_SPRITE_COLS:   cols_r  <= cfg_data[10:0];
        casb_pkg::CFG_SPRITE_ROWS:   rows_r  <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // Clamped sizes
  logic [12:0] scr_w, scr_h;
  logic [10:0] cols, rows;

  assign scr_w = (scr_w_r > casb_pkg::MAX_SCREEN) ? casb_pkg::MAX_SCREEN : scr_w_r;
  assign scr_h = (scr_h_r > casb_pkg::MAX_SCREEN) ? casb_pkg::MAX_SCREEN : scr_h_r;
  assign cols  = (cols_r == 11'd0) ? casb_pkg::MIN_SPRITE :
                 (cols_r > casb_pkg::MAX_SPRITE) ? casb_pkg::MAX_SPRITE : cols_r;
  assign rows  = (rows_r == 11'd0) ? casb_pkg::MIN_SPRITE :
                 (rows_r > casb_pkg::MAX_SPRITE) ? casb_pkg::MAX_SPRITE : rows_r;

  // Pipeline handshake
  logic s1_v_r;
  logic s1_adv;
  logic in_acc;

  assign s1_adv   = !out_valid || !out_stall;
  assign in_stall = s1_v_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  // Texel position and clipping from the counters
  logic [9:0]  col_r, row_r, col_nxt, row_nxt;
  logic [10:0] col_inc, row_inc;
  logic        row_end, last;
  logic [13:0] pos_x, pos_y;
  logic        on_x, on_y;

  assign col_inc = {1'b0, col_r} + 11'd1;
  assign row_inc = {1'b0, row_r} + 11'd1;
  assign row_end = col_inc >= cols;
  assign last    = row_end && (row_inc >= rows);
  assign pos_x   = {left_r[12], left_r} + {4'd0, col_r};
  assign pos_y   = {top_r[12], top_r} + {4'd0, row_r};
  assign on_x    = !pos_x[13] && (pos_x[12:0] < scr_w);
  assign on_y    = !pos_y[13] && (pos_y[12:0] < scr_h);
  assign col_nxt = row_end ? 10'd0 : col_inc[9:0];
  assign row_nxt = !row_end ? row_r : (last ? 10'd0 : row_inc[9:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= 10'd0;
      row_r <= 10'd0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Texel register; an empty stage takes a transfer even while the result waits
  casb_pkg::pix_t s1_src_r, s1_dst_r;
  logic [11:0]    s1_x_r, s1_y_r;
  logic           s1_on_r, s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_adv || !s1_v_r) begin
      s1_v_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_src_r  <= {in_src_alpha, in_src_byte2, in_src_byte1, in_src_byte0};
      s1_dst_r  <= {in_dst_alpha, in_dst_byte2, in_dst_byte1, in_dst_byte0};
      s1_x_r    <= pos_x[11:0];
      s1_y_r    <= pos_y[11:0];
      s1_on_r   <= on_x && on_y;
      s1_last_r <= last;
    end
  end

  // Blend and destination index; an on-screen row times width fits in 24 bits
  casb_pkg::pix_t mix;
  logic [23:0]    row_base;
  logic [23:0]    idx;

  casb_blend u_blend (
    .src (s1_src_r),
    .dst (s1_dst_r),
    .mix (mix)
  );

  assign row_base = {12'd0, s1_y_r} * {11'd0, scr_w};
  assign idx      = s1_on_r ? (row_base + {12'd0, s1_x_r}) : 24'd0;

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_v_r) begin
      out_write_enable <= s1_on_r && (s1_src_r[3] != 8'd0);
      out_pixel_index  <= idx;
      out_byte0        <= mix[0];
      out_byte1        <= mix[1];
      out_byte2        <= mix[2];
      out_alpha        <= mix[3];
      out_last_texel   <= s1_last_r;
    end
  end

  // Checks
  a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && last) |=> (col_r == 10'd0 && row_r == 10'd0))
    else $error("counters did not wrap after last texel");

  a_row_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !row_end) |=> $stable(row_r))
    else $error("row counter moved inside a row");

  a_offscreen: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_v_r && !s1_on_r) |=> (!out_write_enable && out_pixel_index == 24'd0))
    else $error("off-screen texel produced a write or index");

endmodule

`default_nettype wire

/* rtl/core/casb_blend.sv */
// Per-byte alpha blend: floor((s*a + d*(255-a)) / 255) on all four bytes.
// Depends on casb_pkg for the pixel type.
`default_nettype none

module casb_blend (
  input  wire casb_pkg::pix_t src,
  input  wire casb_pkg::pix_t dst,
  output casb_pkg::pix_t      mix
);

  logic [7:0] alpha;
  logic [7:0] inv_alpha;

  assign alpha     = src[3];
  assign inv_alpha = 8'd255 - alpha;

  // Weighted sum stays below 65536; divide by 255 as (n + 1 + (n >> 8)) >> 8
  for (genvar i = 0; i < 4; i++) begin : g_byte
    logic [15:0] num;
    logic [15:0] adj;
    assign num    = ({8'd0, src[i]} * {8'd0, alpha}) + ({8'd0, dst[i]} * {8'd0, inv_alpha});
    assign adj    = num + 16'd1 + {8'd0, num[15:8]};
    assign mix[i] = adj[15:8];
  end

endmodule

`default_nettype wire
